[rtl/core/hfhc_pkg.sv]
// ----------------------------------------------------------------------------
// HDLC frame header checker package
// Shared types, constants and the byte-wide CRC-16/X.25 update.
// ----------------------------------------------------------------------------
package hfhc_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7e;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_INIT    = 16'hffff;
    localparam logic [15:0] CRC_GOOD    = 16'hf0b8;
    localparam logic [7:0]  INFO_FORMAT = 8'h81;
    localparam logic [7:0]  INFO_GROUP  = 8'h80;
    localparam logic [10:0] HCS_MIN_LEN = 11'd7;

    localparam int TDATA_W = 168;
    localparam int TUSER_W = 4;

    // Frame classes reported in the summary.
    typedef enum logic [3:0] {
        KIND_I       = 4'd0,
        KIND_RR      = 4'd1,
        KIND_RNR     = 4'd2,
        KIND_SNRM    = 4'd3,
        KIND_DISC    = 4'd4,
        KIND_UA      = 4'd5,
        KIND_DM      = 4'd6,
        KIND_FRMR    = 4'd7,
        KIND_UI      = 4'd8,
        KIND_UNKNOWN = 4'd9
    } kind_t;

    // Information field parser states.
    typedef enum logic [6:0] {
        PH_FORMAT = 7'b0000001,
        PH_GROUP  = 7'b0000010,
        PH_GLEN   = 7'b0000100,
        PH_PID    = 7'b0001000,
        PH_PLEN   = 7'b0010000,
        PH_PVAL   = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    // One byte through the reflected CRC-16/X.25 register.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // Control byte classification; the order of the tests matters.
    function automatic kind_t classify(input logic [7:0] c);
        kind_t k;
        if (c[0] == 1'b0)                 k = KIND_I;
        else if ((c & 8'h0f) == 8'h01)    k = KIND_RR;
        else if ((c & 8'h0f) == 8'h05)    k = KIND_RNR;
        else if ((c & 8'hef) == 8'h83)    k = KIND_SNRM;
        else if ((c & 8'hef) == 8'h43)    k = KIND_DISC;
        else if ((c & 8'hef) == 8'h63)    k = KIND_UA;
        else if ((c & 8'hef) == 8'h0f)    k = KIND_DM;
        else if ((c & 8'hef) == 8'h87)    k = KIND_FRMR;
        else if ((c & 8'hef) == 8'h03)    k = KIND_UI;
        else                              k = KIND_UNKNOWN;
        return k;
    endfunction

endpackage

[rtl/core/hdlc_frame_header_checker_unit.sv]
// ----------------------------------------------------------------------------
// HDLC frame header checker
// Parses one raw HDLC frame byte per transaction and emits one summary.
// ----------------------------------------------------------------------------
// A summary is registered: the byte that ends the frame is held in the input
// register, then folded into the result register driving the master side.
// Throughput: one byte per cycle while no summary is stalled on the output;
// the byte-wide CRC fold sets the path.
// Reset: rst_n is asynchronous, active low; the block returns to hunting
// for an opening flag with both stages empty.
// ----------------------------------------------------------------------------
module hdlc_frame_header_checker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] segmented, [11:1] frame_length, [19:12] dest_address,
    // [27:20] src_address, [35:28] control_byte, [36] header_crc_ok,
    // [37] frame_crc_ok, [69:38] max_info_tx, [101:70] max_info_rx,
    // [133:102] window_tx, [165:134] window_rx, [167:166] zero
    output logic [hfhc_pkg::TDATA_W-1:0]  m_tdata,
    output logic [hfhc_pkg::TUSER_W-1:0]  m_tuser    // [3:0] frame_kind
);

    // ------------------------------------------------------------------
    // Handshake. The input register holds one byte; it is processed when
    // the result register is empty or being drained in the same cycle.
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          out_valid_reg;
    logic [hfhc_pkg::TDATA_W-1:0]  out_data_reg;
    logic [hfhc_pkg::TUSER_W-1:0]  out_user_reg;

    logic advance;
    logic take_byte;

    assign advance   = !out_valid_reg || m_tready;
    assign take_byte = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // Frame state.
    // ------------------------------------------------------------------
    logic               in_frame_reg,  in_frame_next;
    logic [10:0]        pos_reg,       pos_next;
    logic [15:0]        crc_reg,       crc_next;
    logic [10:0]        len_reg,       len_next;
    logic               seg_reg,       seg_next;
    logic [7:0]         dest_reg,      dest_next;
    logic [7:0]         src_reg,       src_next;
    logic [7:0]         ctrl_reg,      ctrl_next;
    logic               hcs_ok_reg,    hcs_ok_next;
    hfhc_pkg::phase_t   phase_reg,     phase_next;
    logic [7:0]         grp_left_reg,  grp_left_next;
    logic [7:0]         pid_reg,       pid_next;
    logic [7:0]         plen_left_reg, plen_left_next;
    logic [31:0]        acc_reg,       acc_next;
    logic [31:0]        pval_reg [4];
    logic [31:0]        pval_next [4];

    logic               emit;
    logic [11:0]        idx;
    logic [7:0]         b;
    logic [7:0]         grp_dec;
    logic               finish;
    logic [31:0]        finish_val;
    hfhc_pkg::kind_t    kind;
    logic               info_zone;
    logic               fcs_ok;

    assign b       = in_byte_reg;
    assign idx     = {1'b0, pos_reg} + 12'd1;
    assign grp_dec = (grp_left_reg != 8'd0) ? (grp_left_reg - 8'd1) : 8'd0;

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        len_next       = len_reg;
        seg_next       = seg_reg;
        dest_next      = dest_reg;
        src_next       = src_reg;
        ctrl_next      = ctrl_reg;
        hcs_ok_next    = hcs_ok_reg;
        phase_next     = phase_reg;
        grp_left_next  = grp_left_reg;
        pid_next       = pid_reg;
        plen_left_next = plen_left_reg;
        acc_next       = acc_reg;
        for (int i = 0; i < 4; i++) begin
            pval_next[i] = pval_reg[i];
        end
        emit       = 1'b0;
        finish     = 1'b0;
        finish_val = acc_reg;
        kind       = hfhc_pkg::classify(ctrl_reg);
        info_zone  = 1'b0;

        if (take_byte) begin
            if (!in_frame_reg) begin
                // Hunting: only an opening flag starts a frame, and it
                // restarts every piece of per-frame state.
                if (b == hfhc_pkg::FLAG_BYTE) begin
                    in_frame_next  = 1'b1;
                    pos_next       = 11'd0;
                    crc_next       = hfhc_pkg::CRC_INIT;
                    len_next       = 11'd0;
                    seg_next       = 1'b0;
                    dest_next      = 8'd0;
                    src_next       = 8'd0;
                    ctrl_next      = 8'd0;
                    hcs_ok_next    = 1'b1;
                    phase_next     = hfhc_pkg::PH_FORMAT;
                    grp_left_next  = 8'd0;
                    pid_next       = 8'd0;
                    plen_left_next = 8'd0;
                    acc_next       = 32'd0;
                    for (int i = 0; i < 4; i++) begin
                        pval_next[i] = 32'd0;
                    end
                end
            end else begin
                // Header capture by byte offset after the opening flag.
                case (idx)
                    12'd1:
                    begin
                        seg_next       = b[3];
                        len_next[10:8] = b[2:0];
                    end
                    12'd2: len_next[7:0] = b;
                    12'd3: dest_next     = b;
                    12'd4: src_next      = b;
                    12'd5: ctrl_next     = b;
                    default: ;
                endcase

                if (idx <= {1'b0, len_next}) begin
                    crc_next = hfhc_pkg::crc_fold(crc_reg, b);
                end
                if ((idx == 12'd7) && (len_next > hfhc_pkg::HCS_MIN_LEN)) begin
                    hcs_ok_next = (crc_next == hfhc_pkg::CRC_GOOD);
                end

                kind      = hfhc_pkg::classify(ctrl_next);
                info_zone = ((kind == hfhc_pkg::KIND_SNRM) || (kind == hfhc_pkg::KIND_UA))
                            && (len_next > hfhc_pkg::HCS_MIN_LEN)
                            && (idx >= 12'd8)
                            && (({1'b0, idx} + 13'd2) <= {2'b00, len_next});

                // Information field: format, group, group length, then
                // parameters of id, length and big-endian value.
                if (info_zone) begin
                    case (phase_reg)
                        hfhc_pkg::PH_FORMAT:
                        begin
                            phase_next = (b == hfhc_pkg::INFO_FORMAT) ?
                                         hfhc_pkg::PH_GROUP : hfhc_pkg::PH_DONE;
                        end
                        hfhc_pkg::PH_GROUP:
                        begin
                            phase_next = (b == hfhc_pkg::INFO_GROUP) ?
                                         hfhc_pkg::PH_GLEN : hfhc_pkg::PH_DONE;
                        end
                        hfhc_pkg::PH_GLEN:
                        begin
                            grp_left_next = b;
                            phase_next    = (b == 8'd0) ? hfhc_pkg::PH_DONE : hfhc_pkg::PH_PID;
                        end
                        hfhc_pkg::PH_PID:
                        begin
                            pid_next      = b;
                            grp_left_next = grp_dec;
                            phase_next    = hfhc_pkg::PH_PLEN;
                        end
                        hfhc_pkg::PH_PLEN:
                        begin
                            plen_left_next = b;
                            acc_next       = 32'd0;
                            grp_left_next  = grp_dec;
                            if (b == 8'd0) begin
                                finish     = 1'b1;
                                finish_val = 32'd0;
                            end else begin
                                phase_next = hfhc_pkg::PH_PVAL;
                            end
                        end
                        hfhc_pkg::PH_PVAL:
                        begin
                            acc_next       = {acc_reg[23:0], b};
                            grp_left_next  = grp_dec;
                            plen_left_next = plen_left_reg - 8'd1;
                            if (plen_left_reg == 8'd1) begin
                                finish     = 1'b1;
                                finish_val = {acc_reg[23:0], b};
                            end
                        end
                        default: ;
                    endcase

                    // A completed parameter: keep ids 5 to 8, then either
                    // expect the next id or stop at the end of the group.
                    if (finish) begin
                        if ((pid_reg >= 8'd5) && (pid_reg <= 8'd8)) begin
                            pval_next[pid_reg[1:0] - 2'd1] = finish_val;
                        end
                        phase_next = (grp_dec == 8'd0) ? hfhc_pkg::PH_DONE : hfhc_pkg::PH_PID;
                    end
                end

                // The byte at offset length+1 (at least offset 2) ends the
                // frame, whatever its value.
                if ((idx >= 12'd2) && (idx >= ({1'b0, len_next} + 12'd1))) begin
                    emit          = 1'b1;
                    in_frame_next = 1'b0;
                end else begin
                    pos_next = idx[10:0];
                end
            end
        end
    end

    assign fcs_ok = (len_next >= 11'd2) && (crc_next == hfhc_pkg::CRC_GOOD);

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= 8'd0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
            if (s_tvalid) begin
                in_byte_reg <= s_tdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= 11'd0;
            crc_reg       <= hfhc_pkg::CRC_INIT;
            len_reg       <= 11'd0;
            seg_reg       <= 1'b0;
            dest_reg      <= 8'd0;
            src_reg       <= 8'd0;
            ctrl_reg      <= 8'd0;
            hcs_ok_reg    <= 1'b1;
            phase_reg     <= hfhc_pkg::PH_FORMAT;
            grp_left_reg  <= 8'd0;
            pid_reg       <= 8'd0;
            plen_left_reg <= 8'd0;
            acc_reg       <= 32'd0;
            for (int i = 0; i < 4; i++) begin
                pval_reg[i] <= 32'd0;
            end
        end else begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            len_reg       <= len_next;
            seg_reg       <= seg_next;
            dest_reg      <= dest_next;
            src_reg       <= src_next;
            ctrl_reg      <= ctrl_next;
            hcs_ok_reg    <= hcs_ok_next;
            phase_reg     <= phase_next;
            grp_left_reg  <= grp_left_next;
            pid_reg       <= pid_next;
            plen_left_reg <= plen_left_next;
            acc_reg       <= acc_next;
            for (int i = 0; i < 4; i++) begin
                pval_reg[i] <= pval_next[i];
            end
        end
    end

    // Result register: loaded with the summary when a frame ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit) begin
            out_user_reg <= kind;
            out_data_reg <= {2'b00, pval_next[3], pval_next[2], pval_next[1], pval_next[0],
                             fcs_ok, hcs_ok_next, ctrl_next, src_next, dest_next,
                             len_next, seg_next};
        end
    end

endmodule

[rtl/core/hfhc_checker.sv]
// ----------------------------------------------------------------------------
// HDLC frame header checker assertions
// Port-level checks on the summary and input streams, bound to the top level.
// ----------------------------------------------------------------------------
module hfhc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hfhc_pkg::TDATA_W-1:0]  m_tdata,
    input logic [hfhc_pkg::TUSER_W-1:0]  m_tuser
);

    // A stalled summary stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("summary changed while stalled");

    // The input side only pushes back when a summary is stalled.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled summary");

    // Short frames carry no header check, which then reads as good.
    a_hcs_short: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:1] <= 11'd7) |-> m_tdata[36])
        else $error("header check failed on a frame without one");

    // A frame shorter than two bytes cannot carry a valid check sequence.
    a_fcs_short: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:1] < 11'd2) |-> !m_tdata[37])
        else $error("frame check passed on a too short frame");

    // Link parameters come only from SNRM and UA frames.
    a_params: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != hfhc_pkg::KIND_SNRM) && (m_tuser != hfhc_pkg::KIND_UA)
        |-> (m_tdata[165:38] == 128'd0))
        else $error("parameters reported for a frame without them");

endmodule

bind hdlc_frame_header_checker_unit hfhc_checker u_hfhc_checker (.*);

[tb/sv/hdlc_frame_header_checker_unit_tb.sv]
// ----------------------------------------------------------------------------
// HDLC frame header checker testbench
// Builds HDLC frames byte by byte (short, well-formed, SNRM/UA with link
// parameters, corrupted and random), predicts each frame summary in a local
// tracker, and checks every summary transaction field by field, in order.
// ----------------------------------------------------------------------------
module hdlc_frame_header_checker_unit_tb;

    // Control byte templates; the poll/final bit is ORed in separately.
    localparam logic [7:0] CTRL_RR     = 8'h01;
    localparam logic [7:0] CTRL_RNR    = 8'h05;
    localparam logic [7:0] CTRL_SNRM   = 8'h83;
    localparam logic [7:0] CTRL_DISC   = 8'h43;
    localparam logic [7:0] CTRL_UA     = 8'h63;
    localparam logic [7:0] CTRL_DM     = 8'h0f;
    localparam logic [7:0] CTRL_FRMR   = 8'h87;
    localparam logic [7:0] CTRL_UI     = 8'h03;
    localparam logic [7:0] CTRL_PF     = 8'h10;
    localparam logic [7:0] CTRL_U_MASK = 8'hef;
    localparam logic [3:0] CTRL_S_MASK = 4'hf;
    localparam logic [3:0] FMT_TYPE3   = 4'ha;

    // Link parameter ids that the block records (max info tx/rx, window tx/rx).
    localparam logic [7:0] PID_FIRST = 8'd5;
    localparam logic [7:0] PID_LAST  = 8'd8;

    // Byte offsets after the opening flag.
    localparam int OFF_HCS_HI = 7;
    localparam int OFF_INFO   = 8;

    // The long frame uses the upper bits of the length field.
    localparam int BIG_LEN     = 520;
    localparam int ITEM_BUDGET = 1050;
    localparam int IDLE_PCT    = 6;
    localparam int HOLD_START  = 300;
    localparam int HOLD_LEN    = 200;
    localparam int QUIET_START = 700;
    localparam int QUIET_END   = 1000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        hfhc_pkg::kind_t   kind;
        logic              seg;
        logic [10:0]       len;
        logic [7:0]        dest;
        logic [7:0]        src;
        logic [7:0]        ctrl;
        logic              hcs_ok;
        logic              fcs_ok;
        logic [3:0][31:0]  prm;
    } summary_t;

    typedef struct packed {
        logic [7:0]      lead;
        logic            has_lead;
        logic [7:0]      fmt;
        logic [7:0]      len_lo;
        logic [7:0]      dest;
        logic [7:0]      src;
        logic [7:0]      ctrl;
        logic [7:0]      closing;
        logic [47:0]     info;      // information bytes, first one in the top byte
        logic [2:0]      info_n;
        logic            typed;     // expected summary written out in the row
        hfhc_pkg::kind_t want_kind;
        logic            want_hcs;
        logic            want_fcs;
    } frame_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = 8'h00;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [hfhc_pkg::TDATA_W-1:0]   m_tdata;
    logic [hfhc_pkg::TUSER_W-1:0]   m_tuser;

    // Frame tracker state.
    logic              rx_active = 1'b0;
    logic [10:0]       rx_offset = '0;
    logic [15:0]       fcs_reg = hfhc_pkg::CRC_INIT;
    logic [35:0]       hdr_reg = '0;
    logic              hcs_pass = 1'b1;
    hfhc_pkg::phase_t  info_state = hfhc_pkg::PH_FORMAT;
    logic [7:0]        grp_remaining = '0;
    logic [7:0]        param_id = '0;
    logic [7:0]        param_remaining = '0;
    logic [31:0]       param_shift = '0;
    logic [3:0][31:0]  param_table = '0;

    summary_t          pending_summaries [$];
    logic [7:0]        info_q [$];
    logic [7:0]        fbuf [0:2049];
    frame_row_t        directed_rows [0:2];

    int                cyc = 0;
    int                mismatches = 0;
    int                summaries_seen = 0;
    int                frames_sent = 0;
    logic [15:0]       kinds_seen = '0;

    hdlc_frame_header_checker_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    function automatic bit quiet_window();
        return cyc >= QUIET_START && cyc < QUIET_END;
    endfunction

    // Reflected CRC-16/X.25, one data bit at a time, LSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb)
                c = c ^ hfhc_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // Priority order matters: an I frame wins over everything, then the
    // supervisory frames, then the unnumbered ones with P/F masked out.
    function automatic hfhc_pkg::kind_t control_kind(input logic [7:0] c);
        if (!c[0])
            return hfhc_pkg::KIND_I;
        if (c[3:0] == (CTRL_RR[3:0] & CTRL_S_MASK))
            return hfhc_pkg::KIND_RR;
        if (c[3:0] == (CTRL_RNR[3:0] & CTRL_S_MASK))
            return hfhc_pkg::KIND_RNR;
        if ((c & CTRL_U_MASK) == CTRL_SNRM)
            return hfhc_pkg::KIND_SNRM;
        if ((c & CTRL_U_MASK) == CTRL_DISC)
            return hfhc_pkg::KIND_DISC;
        if ((c & CTRL_U_MASK) == CTRL_UA)
            return hfhc_pkg::KIND_UA;
        if ((c & CTRL_U_MASK) == CTRL_DM)
            return hfhc_pkg::KIND_DM;
        if ((c & CTRL_U_MASK) == CTRL_FRMR)
            return hfhc_pkg::KIND_FRMR;
        if ((c & CTRL_U_MASK) == CTRL_UI)
            return hfhc_pkg::KIND_UI;
        return hfhc_pkg::KIND_UNKNOWN;
    endfunction

    function automatic void group_consume();
        if (grp_remaining != 0)
            grp_remaining = grp_remaining - 8'd1;
    endfunction

    function automatic void store_param();
        if (param_id >= PID_FIRST && param_id <= PID_LAST)
            param_table[2'(param_id - PID_FIRST)] = param_shift;
        info_state = (grp_remaining == 0) ? hfhc_pkg::PH_DONE : hfhc_pkg::PH_PID;
    endfunction

    // Information field walk: format, group, group length, then id/len/value.
    function automatic void info_step(input logic [7:0] b);
        case (info_state)
            hfhc_pkg::PH_FORMAT:
                info_state = (b == hfhc_pkg::INFO_FORMAT) ? hfhc_pkg::PH_GROUP
                                                          : hfhc_pkg::PH_DONE;
            hfhc_pkg::PH_GROUP:
                info_state = (b == hfhc_pkg::INFO_GROUP) ? hfhc_pkg::PH_GLEN
                                                         : hfhc_pkg::PH_DONE;
            hfhc_pkg::PH_GLEN:
            begin
                grp_remaining = b;
                info_state = (b == 8'd0) ? hfhc_pkg::PH_DONE : hfhc_pkg::PH_PID;
            end
            hfhc_pkg::PH_PID:
            begin
                param_id = b;
                group_consume();
                info_state = hfhc_pkg::PH_PLEN;
            end
            hfhc_pkg::PH_PLEN:
            begin
                param_remaining = b;
                param_shift = '0;
                group_consume();
                if (b == 8'd0)
                    store_param();
                else
                    info_state = hfhc_pkg::PH_PVAL;
            end
            hfhc_pkg::PH_PVAL:
            begin
                param_shift = {param_shift[23:0], b};
                group_consume();
                param_remaining = param_remaining - 8'd1;
                if (param_remaining == 0)
                    store_param();
            end
            default: ;
        endcase
    endfunction

    // Advances the tracker by one accepted byte; returns 1 with the summary
    // when this byte ends the frame.
    function automatic bit hdlc_track_byte(input logic [7:0] b, output summary_t s);
        int              off;
        logic [10:0]     ln;
        logic [7:0]      ctrl;
        hfhc_pkg::kind_t kind;
        s = '0;
        if (!rx_active)
        begin
            if (b == hfhc_pkg::FLAG_BYTE)
            begin
                rx_active = 1'b1;
                rx_offset = '0;
                fcs_reg = hfhc_pkg::CRC_INIT;
                hdr_reg = '0;
                hcs_pass = 1'b1;
                info_state = hfhc_pkg::PH_FORMAT;
                grp_remaining = '0;
                param_id = '0;
                param_remaining = '0;
                param_shift = '0;
                param_table = '0;
            end
            return 1'b0;
        end
        off = int'(rx_offset) + 1;
        case (off)
            1: hdr_reg[11:8] = b[3:0];
            2: hdr_reg[7:0] = b;
            3: hdr_reg[19:12] = b;
            4: hdr_reg[27:20] = b;
            5: hdr_reg[35:28] = b;
            default: ;
        endcase
        ln = hdr_reg[10:0];
        if (off <= int'(ln))
            fcs_reg = crc_step(fcs_reg, b);
        if (off == OFF_HCS_HI && ln > hfhc_pkg::HCS_MIN_LEN)
            hcs_pass = (fcs_reg == hfhc_pkg::CRC_GOOD);
        ctrl = hdr_reg[35:28];
        kind = control_kind(ctrl);
        if ((kind == hfhc_pkg::KIND_SNRM || kind == hfhc_pkg::KIND_UA)
            && ln > hfhc_pkg::HCS_MIN_LEN && off >= OFF_INFO && off + 2 <= int'(ln))
            info_step(b);
        if (off >= 2 && off >= int'(ln) + 1)
        begin
            s.kind = kind;
            s.seg = hdr_reg[11];
            s.len = ln;
            s.dest = hdr_reg[19:12];
            s.src = hdr_reg[27:20];
            s.ctrl = ctrl;
            s.hcs_ok = hcs_pass;
            s.fcs_ok = (ln >= 11'd2 && fcs_reg == hfhc_pkg::CRC_GOOD);
            s.prm = param_table;
            rx_active = 1'b0;
            return 1'b1;
        end
        rx_offset = off[10:0];
        return 1'b0;
    endfunction

    // Offers one byte, waits for the transaction, then advances the tracker.
    // A typed row replaces the tracker's summary with the one written out.
    task automatic send_byte(input logic [7:0] b, input bit typed, input summary_t want);
        summary_t got;
        if (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT)
        begin
            repeat ($urandom_range(1, 4))
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        if (hdlc_track_byte(b, got))
            pending_summaries.push_back(typed ? want : got);
    endtask

    // Lays out one frame after the opening flag: header, info_q, HCS when
    // length > 7, FCS and closing byte when length >= 7; other bytes random.
    task automatic send_frame(input logic [7:0] fmt, input logic [7:0] len_lo,
                              input logic [7:0] dest, input logic [7:0] src,
                              input logic [7:0] ctrl, input logic [7:0] closing,
                              input bit hcs_good, input bit fcs_good,
                              input bit typed, input summary_t want, output int sent);
        int          ln;
        int          n;
        logic [15:0] c;
        logic [7:0]  flip;
        ln = {fmt[2:0], len_lo};
        n = (ln + 1 < 2) ? 2 : ln + 1;
        fbuf[0] = hfhc_pkg::FLAG_BYTE;
        for (int k = 1; k <= n; k++)
            fbuf[k] = 8'($urandom_range(0, 255));
        fbuf[1] = fmt;
        fbuf[2] = len_lo;
        if (n >= 3)
            fbuf[3] = dest;
        if (n >= 4)
            fbuf[4] = src;
        if (n >= 5)
            fbuf[5] = ctrl;
        for (int k = 0; k < info_q.size() && OFF_INFO + k <= n; k++)
            fbuf[OFF_INFO + k] = info_q[k];
        if (ln > int'(hfhc_pkg::HCS_MIN_LEN))
        begin
            c = hfhc_pkg::CRC_INIT;
            for (int k = 1; k <= 5; k++)
                c = crc_step(c, fbuf[k]);
            c = ~c;
            flip = hcs_good ? 8'h00 : 8'(8'h01 << $urandom_range(0, 7));
            fbuf[6] = c[7:0] ^ flip;
            fbuf[7] = c[15:8];
        end
        if (ln >= int'(hfhc_pkg::HCS_MIN_LEN))
        begin
            c = hfhc_pkg::CRC_INIT;
            for (int k = 1; k <= ln - 2; k++)
                c = crc_step(c, fbuf[k]);
            c = ~c;
            flip = fcs_good ? 8'h00 : 8'(8'h01 << $urandom_range(0, 7));
            fbuf[ln - 1] = c[7:0];
            fbuf[ln] = c[15:8] ^ flip;
            fbuf[ln + 1] = closing;
        end
        for (int k = 0; k <= n; k++)
            send_byte(fbuf[k], typed, want);
        frames_sent++;
        sent = n + 1;
    endtask

    // One random frame. Most are well formed with random content; the rest
    // are short, corrupted or plain noise. With big set, it is the one long
    // UA/SNRM frame whose length reaches into the upper length bits.
    task automatic random_frame(input bit big, output int sent);
        int          r;
        int          ln;
        int          np;
        int          pl;
        int          total;
        logic [3:0]  nib;
        logic [7:0]  fmt;
        logic [7:0]  ctrl;
        logic [7:0]  pf;
        logic [7:0]  junk;
        logic        hg;
        logic        fg;
        summary_t    none;
        none = '0;
        r = big ? 50 : $urandom_range(0, 99);
        info_q.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            // Bytes offered while hunting for a flag must be ignored.
            repeat ($urandom_range(1, 3))
            begin
                junk = 8'($urandom_range(0, 255));
                if (junk == hfhc_pkg::FLAG_BYTE)
                    junk = ~junk;
                send_byte(junk, 1'b0, none);
            end
        end
        nib = ($urandom_range(0, 99) < 80) ? FMT_TYPE3 : 4'($urandom_range(0, 15));
        fmt = {nib, 1'($urandom_range(0, 1)), 3'b000};
        pf = $urandom_range(0, 1) ? CTRL_PF : 8'h00;
        case ($urandom_range(0, 9))
            0: ctrl = {7'($urandom_range(0, 127)), 1'b0};
            1: ctrl = {4'($urandom_range(0, 15)), CTRL_RR[3:0]};
            2: ctrl = {4'($urandom_range(0, 15)), CTRL_RNR[3:0]};
            3: ctrl = CTRL_SNRM | pf;
            4: ctrl = CTRL_DISC | pf;
            5: ctrl = CTRL_UA | pf;
            6: ctrl = CTRL_DM | pf;
            7: ctrl = CTRL_FRMR | pf;
            8: ctrl = CTRL_UI | pf;
            default: ctrl = 8'($urandom_range(0, 255));
        endcase
        hg = ($urandom_range(0, 9) != 0);
        fg = ($urandom_range(0, 9) != 0);
        if (r < 45)
        begin
            ln = $urandom_range(7, 40);
        end
        else if (r < 75)
        begin
            // SNRM/UA with a parameter group: mostly well formed, sometimes
            // with a bad format/group byte, zero or wrong group length.
            ctrl = ($urandom_range(0, 1) ? CTRL_SNRM : CTRL_UA) | pf;
            info_q.push_back(hfhc_pkg::INFO_FORMAT);
            info_q.push_back(hfhc_pkg::INFO_GROUP);
            info_q.push_back(8'h00);
            np = big ? 4 : $urandom_range(0, 5);
            total = 0;
            for (int p = 0; p < np; p++)
            begin
                if (big)
                    info_q.push_back(PID_FIRST + 8'(p));
                else if ($urandom_range(0, 9) < 8)
                    info_q.push_back(8'($urandom_range(PID_FIRST, PID_LAST)));
                else
                    info_q.push_back(8'($urandom_range(0, 255)));
                pl = big ? 4 : (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                            : $urandom_range(0, 6));
                info_q.push_back(8'(pl));
                repeat (pl)
                    info_q.push_back(8'($urandom_range(0, 255)));
                total += 2 + pl;
            end
            info_q[2] = 8'(total);
            case (big ? 9 : $urandom_range(0, 19))
                0: info_q[0] = 8'($urandom_range(0, 255));
                1: info_q[1] = 8'($urandom_range(0, 255));
                2: info_q[2] = 8'h00;
                3: info_q[2] = 8'($urandom_range(0, total));
                default: ;
            endcase
            ln = OFF_INFO + info_q.size() + 1;
            if ($urandom_range(0, 9) == 0)
                ln = $urandom_range(OFF_INFO, ln);
            if (big)
            begin
                ln = BIG_LEN;
                hg = 1'b1;
                fg = 1'b1;
            end
        end
        else if (r < 90)
        begin
            ln = $urandom_range(0, 7);
        end
        else
        begin
            ctrl = 8'($urandom_range(0, 255));
            ln = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
            hg = $urandom_range(0, 1);
            fg = $urandom_range(0, 1);
        end
        fmt[2:0] = 3'(ln >> 8);
        send_frame(fmt, 8'(ln), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), ctrl,
                   ($urandom_range(0, 9) != 0) ? hfhc_pkg::FLAG_BYTE
                                               : 8'($urandom_range(0, 255)),
                   hg, fg, 1'b0, none, sent);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("summary %0d field %s: expected 0x%0h, got 0x%0h",
                         summaries_seen, name, want, got);
        end
    endtask

    // Every summary transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin
        summary_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            summaries_seen++;
            kinds_seen[m_tuser] = 1'b1;
            if (pending_summaries.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("summary %0d arrived with nothing expected (tdata 0x%0h)",
                             summaries_seen, m_tdata);
            end
            else
            begin
                want = pending_summaries.pop_front();
                check_field("frame_kind", 32'(want.kind), 32'(m_tuser));
                check_field("segmented", 32'(want.seg), 32'(m_tdata[0]));
                check_field("frame_length", 32'(want.len), 32'(m_tdata[11:1]));
                check_field("dest_address", 32'(want.dest), 32'(m_tdata[19:12]));
                check_field("src_address", 32'(want.src), 32'(m_tdata[27:20]));
                check_field("control_byte", 32'(want.ctrl), 32'(m_tdata[35:28]));
                check_field("header_crc_ok", 32'(want.hcs_ok), 32'(m_tdata[36]));
                check_field("frame_crc_ok", 32'(want.fcs_ok), 32'(m_tdata[37]));
                check_field("max_info_tx", want.prm[0], m_tdata[69:38]);
                check_field("max_info_rx", want.prm[1], m_tdata[101:70]);
                check_field("window_tx", want.prm[2], m_tdata[133:102]);
                check_field("window_rx", want.prm[3], m_tdata[165:134]);
                check_field("tdata_pad", 32'd0, 32'(m_tdata[167:166]));
            end
        end
    end

    // Result side: random back-pressure, one long hold-off that fills the
    // block and stalls its input, and a stretch with no back-pressure.
    initial
    begin : summary_sink
        int rx_cycles;
        rx_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_tready <= 1'b0;
            else
            begin
                rx_cycles++;
                if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN)
                    m_tready <= 1'b0;
                else if (quiet_window())
                    m_tready <= 1'b1;
                else
                    m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d summaries still outstanding", pending_summaries.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : byte_source
        int        sent;
        int        bytes_sent;
        bit        big_sent;
        summary_t  want;
        frame_row_t row;

        // Directed frames: idle bytes ahead of the flag, zero and one byte
        // lengths (summary after the length byte, nothing else captured),
        // and an SNRM with a flag byte as data, one link parameter and a
        // closing byte that is not a flag.
        directed_rows[0] = '{8'h00, 1'b1, 8'ha0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                             48'h0, 3'd0, 1'b1, hfhc_pkg::KIND_I, 1'b1, 1'b0};
        directed_rows[1] = '{8'hff, 1'b1, 8'ha8, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                             48'h0, 3'd0, 1'b1, hfhc_pkg::KIND_I, 1'b1, 1'b0};
        directed_rows[2] = '{8'h00, 1'b0, 8'ha0, 8'h0f, hfhc_pkg::FLAG_BYTE, 8'hff,
                             CTRL_SNRM | CTRL_PF, 8'h00, 48'h81_80_03_05_01_80, 3'd6,
                             1'b0, hfhc_pkg::KIND_SNRM, 1'b1, 1'b1};
        bytes_sent = 0;
        big_sent = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 3; i++)
        begin
            row = directed_rows[i];
            want = '0;
            want.kind = row.want_kind;
            want.seg = row.fmt[3];
            want.len = {row.fmt[2:0], row.len_lo};
            want.hcs_ok = row.want_hcs;
            want.fcs_ok = row.want_fcs;
            if (row.has_lead)
                send_byte(row.lead, 1'b0, want);
            info_q.delete();
            for (int k = 0; k < row.info_n; k++)
                info_q.push_back(row.info[47 - 8 * k -: 8]);
            send_frame(row.fmt, row.len_lo, row.dest, row.src, row.ctrl, row.closing,
                       1'b1, 1'b1, row.typed, want, sent);
            bytes_sent += sent;
        end

        while (bytes_sent < ITEM_BUDGET)
        begin
            if (!big_sent && bytes_sent >= ITEM_BUDGET / 2)
            begin
                random_frame(1'b1, sent);
                big_sent = 1'b1;
            end
            else
            begin
                random_frame(1'b0, sent);
            end
            bytes_sent += sent;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (pending_summaries.size() != 0)
            mismatches += pending_summaries.size();
        $display("Sent %0d frames in %0d bytes with idle noise and one long frame;",
                 frames_sent, bytes_sent);
        $display("checked %0d summaries, saw %0d of 10 kinds, held off %0d cycles; %0d errors.",
                 summaries_seen, $countones(kinds_seen), HOLD_LEN, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[hdlc_frame_header_checker_unit.f]
rtl/core/hfhc_pkg.sv
rtl/core/hdlc_frame_header_checker_unit.sv
rtl/core/hfhc_checker.sv
tb/sv/hdlc_frame_header_checker_unit_tb.sv
